/* design/playfair_pkg.sv */
// ----------------------------------------------------------------------------
// Playfair cipher package
// Key square, character constants and the pair lookup functions.
// ----------------------------------------------------------------------------
package playfair_pkg;

   localparam int unsigned SquareDim = 5;

   localparam logic [7:0] CHAR_A = 8'h41;
   localparam logic [7:0] CHAR_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOW_A = 8'h61;
   localparam logic [7:0] CHAR_LOW_Z = 8'h7A;
   localparam logic [7:0] CHAR_I = 8'h49;
   localparam logic [7:0] CHAR_J = 8'h4A;
   localparam logic [7:0] CHAR_X = 8'h58;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   localparam logic [7:0] SQUARE [SquareDim][SquareDim] = '{
      '{8'h4C, 8'h49, 8'h53, 8'h54, 8'h45},
      '{8'h52, 8'h41, 8'h42, 8'h43, 8'h44},
      '{8'h46, 8'h47, 8'h48, 8'h4B, 8'h4D},
      '{8'h4E, 8'h4F, 8'h50, 8'h51, 8'h55},
      '{8'h56, 8'h57, 8'h58, 8'h59, 8'h5A}
   };

   typedef struct packed {
      logic       found;
      logic [2:0] row;
      logic [2:0] col;
   } loc_type;

   typedef struct packed {
      logic [7:0] x;
      logic [7:0] y;
      logic       err;
   } pair_type;

   typedef struct packed {
      logic [7:0] letter;
      logic       last;
      logic       err;
   } rsp_type;

   function automatic logic [7:0] to_upper(input logic [7:0] b);
      if (b >= CHAR_LOW_A && b <= CHAR_LOW_Z) begin
         return b - CASE_OFFSET;
      end
      return b;
   endfunction

   function automatic loc_type locate(input logic [7:0] ch);
      loc_type res;
      res = '0;
      for (int r = 0; r < SquareDim; r++) begin
         for (int c = 0; c < SquareDim; c++) begin
            if (SQUARE[r][c] == ch) begin
               res.found = 1'b1;
               res.row   = 3'(r);
               res.col   = 3'(c);
            end
         end
      end
      return res;
   endfunction

   function automatic logic [2:0] step(input logic [2:0] v, input logic dec);
      if (dec) begin
         return (v == 3'd0) ? 3'(SquareDim - 1) : v - 3'd1;
      end
      return (v == 3'(SquareDim - 1)) ? 3'd0 : v + 3'd1;
   endfunction

   function automatic pair_type cipher_pair(input logic [7:0] a, input logic [7:0] b,
                                            input logic dec);
      loc_type  la;
      loc_type  lb;
      pair_type res;
      la = locate(a);
      lb = locate(b);
      res.err = 1'b0;
      if (!(la.found && lb.found)) begin
         res.x   = a;
         res.y   = b;
         res.err = 1'b1;
      end else if (la.row == lb.row) begin
         res.x = SQUARE[la.row][step(la.col, dec)];
         res.y = SQUARE[lb.row][step(lb.col, dec)];
      end else if (la.col == lb.col) begin
         res.x = SQUARE[step(la.row, dec)][la.col];
         res.y = SQUARE[step(lb.row, dec)][lb.col];
      end else begin
         res.x = SQUARE[la.row][lb.col];
         res.y = SQUARE[lb.row][la.col];
      end
      return res;
   endfunction

endpackage

/* design/playfair_digraph_cipher.sv */
// ----------------------------------------------------------------------------
// Playfair digraph cipher
// Streams raw text bytes through a fixed-key Playfair cipher, one letter out
// per transaction, with encrypt-side text preparation and decrypt mode.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  req_*     in         tdata: in_byte[7:0]; tlast: end_of_text
//  rsp_*     out        tdata: out_letter[7:0]; tlast: last; tuser: error
//  csr_*     in         csr_data: mode (0 encrypt, 1 decrypt)
//
//  A byte is resolved in the cycle it is accepted; its pair lands in a
//  two-slot result register. The result port moves one letter per cycle
//  while rsp_tready is high, so a byte that completes a pair holds the port
//  for both letters. A new byte is taken while the last waiting letter
//  leaves. Reset clears mode, history, the held letter and the result slots.
// ----------------------------------------------------------------------------
module playfair_digraph_cipher (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // in_byte[7:0]
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // out_letter[7:0]
   output logic       rsp_tlast,
   output logic       rsp_tuser,   // error
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_data
);

   logic                  mode_ff, mode_in;
   logic [7:0]            prev_raw_ff, prev_raw_in;
   logic                  prev_letter_ff, prev_letter_in;
   logic [7:0]            held_byte_ff, held_byte_in;
   logic                  held_valid_ff, held_valid_in;
   logic [1:0]            count_ff, count_in;
   playfair_pkg::rsp_type slot0_ff, slot0_in;
   playfair_pkg::rsp_type slot1_ff, slot1_in;

   logic                   accept;
   logic [7:0]             up;
   logic                   letter;
   logic [7:0]             ch;
   logic                   dbl;
   logic                   emit_pair;
   logic                   emit_drop;
   logic [7:0]             pair_a;
   logic [7:0]             pair_b;
   logic                   pair_dec;
   playfair_pkg::pair_type pair;

   assign csr_ready  = 1'b1;
   assign req_tready = (count_ff == 2'd0) || (count_ff == 2'd1 && rsp_tready);
   assign accept     = req_tvalid && req_tready;

   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tdata  = slot0_ff.letter;
   assign rsp_tlast  = slot0_ff.last;
   assign rsp_tuser  = slot0_ff.err;

   assign up     = playfair_pkg::to_upper(req_tdata);
   assign letter = (up >= playfair_pkg::CHAR_A) && (up <= playfair_pkg::CHAR_Z);
   assign ch     = (up == playfair_pkg::CHAR_J) ? playfair_pkg::CHAR_I : up;
   assign dbl    = prev_letter_ff && (playfair_pkg::to_upper(prev_raw_ff) == up);
   assign pair   = playfair_pkg::cipher_pair(pair_a, pair_b, pair_dec);

   always_comb begin
      mode_in        = mode_ff;
      prev_raw_in    = prev_raw_ff;
      prev_letter_in = prev_letter_ff;
      held_byte_in   = held_byte_ff;
      held_valid_in  = held_valid_ff;
      emit_pair      = 1'b0;
      emit_drop      = 1'b0;
      pair_a         = held_byte_ff;
      pair_b         = playfair_pkg::CHAR_X;
      pair_dec       = mode_ff;

      if (csr_valid) begin
         mode_in = csr_data;
      end

      if (accept) begin
         if (req_tlast) begin
            if (held_valid_ff) begin
               if (!mode_ff) begin
                  emit_pair = 1'b1;
               end else begin
                  emit_drop = 1'b1;
               end
            end
            held_valid_in  = 1'b0;
            prev_raw_in    = '0;
            prev_letter_in = 1'b0;
         end else begin
            prev_raw_in    = req_tdata;
            prev_letter_in = letter;
            if (!mode_ff) begin
               if (letter) begin
                  if (held_valid_ff) begin
                     emit_pair = 1'b1;
                     if (dbl) begin
                        held_byte_in = ch;
                     end else begin
                        pair_b        = ch;
                        held_valid_in = 1'b0;
                     end
                  end else if (dbl) begin
                     emit_pair = 1'b1;
                     pair_a    = playfair_pkg::CHAR_X;
                     pair_b    = ch;
                  end else begin
                     held_byte_in  = ch;
                     held_valid_in = 1'b1;
                  end
               end
            end else begin
               if (held_valid_ff) begin
                  emit_pair     = 1'b1;
                  pair_b        = up;
                  held_valid_in = 1'b0;
               end else begin
                  held_byte_in  = up;
                  held_valid_in = 1'b1;
               end
            end
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (rsp_tvalid && rsp_tready) begin
         count_in = count_ff - 2'd1;
         slot0_in = slot1_ff;
      end
      if (emit_pair) begin
         count_in = 2'd2;
         slot0_in = '{letter: pair.x, last: 1'b0, err: pair.err};
         slot1_in = '{letter: pair.y, last: 1'b1, err: pair.err};
      end else if (emit_drop) begin
         count_in = 2'd1;
         slot0_in = '{letter: 8'h00, last: 1'b1, err: 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= 1'b0;
         prev_raw_ff    <= '0;
         prev_letter_ff <= 1'b0;
         held_valid_ff  <= 1'b0;
         count_ff       <= '0;
      end else begin
         mode_ff        <= mode_in;
         prev_raw_ff    <= prev_raw_in;
         prev_letter_ff <= prev_letter_in;
         held_valid_ff  <= held_valid_in;
         count_ff       <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      held_byte_ff <= held_byte_in;
      slot0_ff     <= slot0_in;
      slot1_ff     <= slot1_in;
   end

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// Playfair digraph cipher testbench
// Drives raw text bytes and end-of-text markers into the cipher over the
// request stream and checks every letter on the response stream against an
// in-bench cipher model. A directed table covers the key square rules,
// padding, double letters, bytes outside the square, odd leftovers and mode
// changes in the middle of a message. Random messages follow under three
// backpressure profiles.
// ----------------------------------------------------------------------------
module testbench;

   localparam logic MODE_ENCRYPT = 1'b0;
   localparam logic MODE_DECRYPT = 1'b1;

   localparam logic [7:0] PAD_LETTER = "X";
   localparam logic [7:0] LETTER_J   = "J";
   localparam logic [7:0] LETTER_I   = "I";

   localparam logic [199:0] KEY_SQUARE = "LISTERABCDFGHKMNOPQUVWXYZ";

   localparam int SettleCycles = 8;

   typedef struct packed {
      logic [7:0] letter;
      logic       last;
      logic       err;
   } letter_type;

   typedef struct packed {
      logic       is_cfg;
      logic [7:0] data;
      logic       eot;
      logic       known;
      logic [1:0] count;
      letter_type r0;
      letter_type r1;
   } stim_row_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;
   logic       req_tlast;
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;
   logic       rsp_tuser;
   logic       csr_valid;
   logic       csr_ready;
   logic       csr_data;

   logic       cipher_mode;
   logic [7:0] last_raw;
   logic       last_was_alpha;
   logic [7:0] pending_char;
   logic       pending_valid;

   letter_type   step_results[$];
   letter_type   letter_queue[$];
   stim_row_type stim_rows[$];

   int         send_idle_pct;
   int         recv_idle_pct;
   int         mismatches;

   playfair_digraph_cipher dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #3_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic logic [7:0] upcase(input logic [7:0] b);
      if (b >= "a" && b <= "z") begin
         return b - 8'd32;
      end
      return b;
   endfunction

   function automatic logic is_alpha(input logic [7:0] b);
      logic [7:0] u;
      u = upcase(b);
      return u >= "A" && u <= "Z";
   endfunction

   function automatic logic [7:0] cell_at(input int r, input int c);
      return KEY_SQUARE[8 * (24 - (r * 5 + c)) +: 8];
   endfunction

   function automatic logic find_cell(input logic [7:0] ch, output int r, output int c);
      r = 0;
      c = 0;
      for (int i = 0; i < 25; i++) begin
         if (cell_at(i / 5, i % 5) == ch) begin
            r = i / 5;
            c = i % 5;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic letter_type letter_of(input logic [7:0] ch, input logic lst,
                                            input logic err);
      letter_type v;
      v.letter = ch;
      v.last   = lst;
      v.err    = err;
      return v;
   endfunction

   function automatic void cipher_pair(input logic [7:0] a, input logic [7:0] b,
                                       input int shift);
      int         r1, c1, r2, c2;
      logic       ok_a, ok_b;
      logic [7:0] x, y;
      ok_a = find_cell(a, r1, c1);
      ok_b = find_cell(b, r2, c2);
      if (!(ok_a && ok_b)) begin
         step_results.push_back(letter_of(a, 1'b0, 1'b1));
         step_results.push_back(letter_of(b, 1'b1, 1'b1));
      end else begin
         if (r1 == r2) begin
            x = cell_at(r1, (c1 + shift) % 5);
            y = cell_at(r2, (c2 + shift) % 5);
         end else if (c1 == c2) begin
            x = cell_at((r1 + shift) % 5, c1);
            y = cell_at((r2 + shift) % 5, c2);
         end else begin
            x = cell_at(r1, c2);
            y = cell_at(r2, c1);
         end
         step_results.push_back(letter_of(x, 1'b0, 1'b0));
         step_results.push_back(letter_of(y, 1'b1, 1'b0));
      end
   endfunction

   function automatic void pair_up(input logic [7:0] ch);
      if (pending_valid) begin
         pending_valid = 1'b0;
         cipher_pair(pending_char, ch, (cipher_mode == MODE_DECRYPT) ? 4 : 1);
         pending_char = 8'h00;
      end else begin
         pending_char  = ch;
         pending_valid = 1'b1;
      end
   endfunction

   function automatic void predict_text(input logic [7:0] b, input logic eot);
      logic [7:0] up;
      logic       alpha;
      step_results.delete();
      if (eot) begin
         if (pending_valid) begin
            if (cipher_mode == MODE_ENCRYPT) begin
               cipher_pair(pending_char, PAD_LETTER, 1);
            end else begin
               step_results.push_back(letter_of(8'h00, 1'b1, 1'b1));
            end
         end
         pending_valid  = 1'b0;
         pending_char   = 8'h00;
         last_raw       = 8'h00;
         last_was_alpha = 1'b0;
      end else begin
         up    = upcase(b);
         alpha = is_alpha(b);
         if (cipher_mode == MODE_ENCRYPT) begin
            if (alpha) begin
               if (last_was_alpha && upcase(last_raw) == up) begin
                  pair_up(PAD_LETTER);
               end
               pair_up((up == LETTER_J) ? LETTER_I : up);
            end
         end else begin
            pair_up(up);
         end
         last_raw       = b;
         last_was_alpha = alpha;
      end
   endfunction

   function automatic void add_text(input logic [7:0] b, input logic eot);
      stim_row_type row;
      row        = '0;
      row.data   = b;
      row.eot    = eot;
      stim_rows.push_back(row);
   endfunction

   function automatic void add_known(input logic [7:0] b, input logic eot,
                                     input logic [1:0] count, input letter_type r0,
                                     input letter_type r1);
      stim_row_type row;
      row        = '0;
      row.data   = b;
      row.eot    = eot;
      row.known  = 1'b1;
      row.count  = count;
      row.r0     = r0;
      row.r1     = r1;
      stim_rows.push_back(row);
   endfunction

   function automatic void add_mode(input logic m);
      stim_row_type row;
      row        = '0;
      row.is_cfg = 1'b1;
      row.data   = {7'd0, m};
      stim_rows.push_back(row);
   endfunction

   // Enter and leave at a falling edge.
   task automatic send_text(input logic [7:0] b, input logic eot, input logic known,
                            input logic [1:0] count, input letter_type r0,
                            input letter_type r1);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eot;
      do @(posedge clock); while (!req_tready);
      predict_text(b, eot);
      if (known) begin
         if (count > 0) letter_queue.push_back(r0);
         if (count > 1) letter_queue.push_back(r1);
      end else begin
         foreach (step_results[i]) letter_queue.push_back(step_results[i]);
      end
      @(negedge clock);
   endtask

   task automatic write_mode(input logic m);
      req_tvalid <= 1'b0;
      while (letter_queue.size() != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= m;
      do @(posedge clock); while (!csr_ready);
      cipher_mode = m;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin : response_check
      letter_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = letter_of(rsp_tdata, rsp_tlast, rsp_tuser);
         if (letter_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected letter %h last %b error %b",
                        got.letter, got.last, got.err);
            end
         end else begin
            want = letter_queue.pop_front();
            if (want.letter !== got.letter || want.last !== got.last ||
                want.err !== got.err) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("letter mismatch: expected %h last %b error %b,",
                           want.letter, want.last, want.err,
                           " got %h last %b error %b",
                           got.letter, got.last, got.err);
               end
            end
         end
      end
   end

   initial begin
      logic [7:0]   b;
      logic         eot;
      int           roll;
      int           taken;
      stim_row_type row;

      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = 8'h00;
      req_tlast      = 1'b0;
      rsp_tready     = 1'b0;
      csr_valid      = 1'b0;
      csr_data       = 1'b0;
      send_idle_pct  = 0;
      recv_idle_pct  = 0;
      mismatches     = 0;
      cipher_mode    = MODE_ENCRYPT;
      last_raw       = 8'h00;
      last_was_alpha = 1'b0;
      pending_char   = 8'h00;
      pending_valid  = 1'b0;

      // Encrypt mode after reset.
      add_known(8'h00, 1'b1, 2'd0, '0, '0);
      add_text("L", 1'b0);
      add_known("I", 1'b0, 2'd2, letter_of("I", 1'b0, 1'b0), letter_of("S", 1'b1, 1'b0));
      add_text("a", 1'b0);
      add_text("a", 1'b0);
      add_text("j", 1'b0);
      add_text(8'h00, 1'b0);
      add_text(8'hFF, 1'b0);
      add_text("!", 1'b0);
      add_text("Z", 1'b0);
      add_known(8'hFF, 1'b1, 2'd2, letter_of("V", 1'b0, 1'b0), letter_of("Y", 1'b1, 1'b0));
      add_text("e", 1'b0);
      add_text("Z", 1'b0);
      add_text("Q", 1'b0);
      // Decrypt mode, the held Q pairs under the new rules.
      add_mode(MODE_DECRYPT);
      add_text("U", 1'b0);
      add_text("I", 1'b0);
      add_text("s", 1'b0);
      add_text("J", 1'b0);
      add_known("A", 1'b0, 2'd2, letter_of("J", 1'b0, 1'b1), letter_of("A", 1'b1, 1'b1));
      add_text(8'h00, 1'b0);
      add_known(8'hFF, 1'b0, 2'd2, letter_of(8'h00, 1'b0, 1'b1),
                letter_of(8'hFF, 1'b1, 1'b1));
      add_text("k", 1'b0);
      add_mode(MODE_ENCRYPT);
      add_text("K", 1'b0);
      add_text(8'hFF, 1'b1);
      add_mode(MODE_DECRYPT);
      add_text("Q", 1'b0);
      add_known(8'h00, 1'b1, 2'd1, letter_of(8'h00, 1'b1, 1'b1), '0);
      add_known("A", 1'b1, 2'd0, '0, '0);
      add_mode(MODE_ENCRYPT);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (stim_rows[i]) begin
         row = stim_rows[i];
         if (row.is_cfg) begin
            write_mode(row.data[0]);
         end else begin
            send_text(row.data, row.eot, row.known, row.count, row.r0, row.r1);
         end
      end

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 82 : 0;
         recv_idle_pct = (phase == 0) ? 82 : (phase == 1) ? 34 : 0;
         write_mode(phase == 1);
         taken = 0;
         while (taken < 534) begin
            if ($urandom_range(79) == 0) begin
               write_mode(1'($urandom_range(1)));
            end
            roll = $urandom_range(99);
            eot  = 1'b0;
            if (roll < 7) begin
               eot = 1'b1;
               b   = 8'($urandom_range(255));
            end else if (roll < 15) begin
               b = 8'($urandom_range(255));
            end else if (cipher_mode == MODE_ENCRYPT && roll < 30 && last_was_alpha) begin
               b = last_raw ^ ($urandom_range(1) ? 8'h20 : 8'h00);
            end else if (cipher_mode == MODE_ENCRYPT) begin
               b = 8'd65 + 8'($urandom_range(25)) + ($urandom_range(1) ? 8'h20 : 8'h00);
            end else begin
               b = cell_at($urandom_range(4), $urandom_range(4));
               if ($urandom_range(3) == 0) b = b + 8'h20;
            end
            send_text(b, eot, 1'b0, 2'd0, '0, '0);
            // Skipped bytes in encrypt mode do no work.
            if (eot || cipher_mode == MODE_DECRYPT || is_alpha(b)) taken++;
         end
      end

      req_tvalid <= 1'b0;
      while (letter_queue.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);

      if (mismatches == 0 && letter_queue.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

/* filelist.f */
design/playfair_pkg.sv
design/playfair_digraph_cipher.sv
tb/testbench.sv
